// ----- rtl/ddd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and the month table of the day distance pipeline.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DistW  = 22;
  localparam int unsigned DnumW  = 23;  // day number since the start of year 0
  localparam int unsigned DoyW   = 9;   // month offset plus day, at most 396
  localparam int unsigned Q4W    = 13;
  localparam int unsigned Q100W  = 8;
  localparam int unsigned Q400W  = 6;
  localparam int unsigned ProdW  = 30;

  // Division by 100 through a reciprocal: exact for dividends below 43690.
  localparam int unsigned Div100Mul   = 20972;
  localparam int unsigned Div100Shift = 21;

  localparam logic [DnumW-1:0] DistMax = DnumW'((1 << DistW) - 1);

  typedef logic [DnumW-1:0] dnum_t;

  // Per-date word between the first and second stage.
  typedef struct packed {
    logic [YearW-1:0] year;
    logic             late;     // month is March or later
    logic [DoyW-1:0]  doy;      // common-year day of year
    logic [Q4W-1:0]   q4;       // (year + 3) / 4
    logic [Q100W-1:0] q100;     // year / 100
    logic [Q100W-1:0] q100a;    // (year + 99) / 100
    logic [Q400W-1:0] q400;     // (year + 399) / 400
  } date_split_t;

  // Days in the months before month m of a common year.
  function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/date_difference_days.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_difference_days
// Absolute number of days between two Gregorian dates, three-stage pipeline.
// ----------------------------------------------------------------------------
// The block accepts one word of two dates per clock cycle as long as the
// output is not stalled, passes each word through the split, day number
// and distance registers in turn, and sustains one word per cycle then.
// Stage one splits each year by reciprocal multiplication (one 15x15 multiply
// per quotient by 100 or 400, a shift for the quotient by four), stage two
// builds each day number since the start of year 0 with the leap rule of the
// Gregorian calendar, and stage three takes the absolute difference and
// saturates it to 22 bits. Days are not checked against the month length; a
// day past the month end simply runs into the next month. Each stage holds
// its word while the next is full and stalled, so back pressure on the output
// reaches the input in the same cycle and no word is dropped or repeated.
// ----------------------------------------------------------------------------
module date_difference_days (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ddd_pkg::DayW-1:0]     first_day_i,
  input  logic [ddd_pkg::MonthW-1:0]   first_month_i,
  input  logic [ddd_pkg::YearW-1:0]    first_year_i,
  input  logic [ddd_pkg::DayW-1:0]     second_day_i,
  input  logic [ddd_pkg::MonthW-1:0]   second_month_i,
  input  logic [ddd_pkg::YearW-1:0]    second_year_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ddd_pkg::DistW-1:0]    day_distance_o
);

  // Stage valid flags.
  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  // Per-stage advance enables: a stage loads when it is empty or moves on.
  logic adv1, adv2, adv3;

  ddd_pkg::date_split_t split_a_d, split_b_d, split_a_q, split_b_q;
  ddd_pkg::dnum_t       dn_a_d, dn_b_d, dn_a_q, dn_b_q;
  ddd_pkg::dnum_t       diff;
  logic [ddd_pkg::DistW-1:0] dist_d, dist_q;

  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  ddd_date_split u_split_a (
    .day_i   (first_day_i),
    .month_i (first_month_i),
    .year_i  (first_year_i),
    .split_o (split_a_d)
  );

  ddd_date_split u_split_b (
    .day_i   (second_day_i),
    .month_i (second_month_i),
    .year_i  (second_year_i),
    .split_o (split_b_d)
  );

  ddd_day_count u_count_a (
    .split_i (split_a_q),
    .dnum_o  (dn_a_d)
  );

  ddd_day_count u_count_b (
    .split_i (split_b_q),
    .dnum_o  (dn_b_d)
  );

  // The distance is symmetric, so the order of the dates does not matter.
  always_comb begin
    diff   = (dn_a_q > dn_b_q) ? (dn_a_q - dn_b_q) : (dn_b_q - dn_a_q);
    dist_d = (diff > ddd_pkg::DistMax) ? ddd_pkg::DistMax[ddd_pkg::DistW-1:0]
                                       : diff[ddd_pkg::DistW-1:0];
  end

  always_comb begin
    v1_d = adv1 ? in_valid_i : v1_q;
    v2_d = adv2 ? v1_q       : v2_q;
    v3_d = adv3 ? v2_q       : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Payload registers load only with their stage, so a stalled word holds.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      split_a_q <= split_a_d;
      split_b_q <= split_b_d;
    end
    if (adv2) begin
      dn_a_q <= dn_a_d;
      dn_b_q <= dn_b_d;
    end
    if (adv3) begin
      dist_q <= dist_d;
    end
  end

  assign out_valid_o    = v3_q;
  assign day_distance_o = dist_q;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word did not reach the first stage");

  a_s1_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !in_ready_o) |=> v1_q)
    else $error("first stage word lost while stalled");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && v3_q && !out_ready_i) |=> (v2_q && $stable(dn_a_q) && $stable(dn_b_q)))
    else $error("second stage word changed while stalled");

  a_equal_dates_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && adv3 && (dn_a_q == dn_b_q)) |=> (out_valid_o && (day_distance_o == '0)))
    else $error("equal day numbers gave a nonzero distance");
`endif

endmodule

// ----- rtl/ddd_date_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_date_split
// First stage logic: year quotients by reciprocal multiplication and the
// common-year day of year.
// ----------------------------------------------------------------------------
module ddd_date_split (
  input  logic [ddd_pkg::DayW-1:0]   day_i,
  input  logic [ddd_pkg::MonthW-1:0] month_i,
  input  logic [ddd_pkg::YearW-1:0]  year_i,
  output ddd_pkg::date_split_t       split_o
);

  logic [ddd_pkg::YearW:0]   y_ext;
  logic [ddd_pkg::YearW:0]   y_p3;
  logic [ddd_pkg::YearW:0]   y_p99;
  logic [ddd_pkg::YearW:0]   y_p399;
  logic [ddd_pkg::ProdW-1:0] prod0;
  logic [ddd_pkg::ProdW-1:0] prod99;
  logic [ddd_pkg::ProdW-1:0] prod399;
  logic [ddd_pkg::Q100W-1:0] q399;

  assign y_ext  = {1'b0, year_i};
  assign y_p3   = y_ext + 15'd3;
  assign y_p99  = y_ext + 15'd99;
  assign y_p399 = y_ext + 15'd399;

  assign prod0   = ddd_pkg::ProdW'(y_ext)  * ddd_pkg::ProdW'(ddd_pkg::Div100Mul);
  assign prod99  = ddd_pkg::ProdW'(y_p99)  * ddd_pkg::ProdW'(ddd_pkg::Div100Mul);
  assign prod399 = ddd_pkg::ProdW'(y_p399) * ddd_pkg::ProdW'(ddd_pkg::Div100Mul);
  assign q399    = prod399[ddd_pkg::Div100Shift +: ddd_pkg::Q100W];

  always_comb begin
    split_o.year  = year_i;
    split_o.late  = (month_i >= 4'd3);
    split_o.doy   = ddd_pkg::cum_days(month_i) + ddd_pkg::DoyW'(day_i);
    split_o.q4    = y_p3[ddd_pkg::YearW:2];
    split_o.q100  = prod0[ddd_pkg::Div100Shift +: ddd_pkg::Q100W];
    split_o.q100a = prod99[ddd_pkg::Div100Shift +: ddd_pkg::Q100W];
    split_o.q400  = q399[ddd_pkg::Q100W-1:2];
  end

endmodule

// ----- rtl/ddd_day_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_day_count
// Second stage logic: leap decision and the absolute day number of a date.
// ----------------------------------------------------------------------------
module ddd_day_count (
  input  ddd_pkg::date_split_t split_i,
  output ddd_pkg::dnum_t       dnum_o
);

  logic                     year_div4;
  logic                     year_div100;
  logic                     leap;
  logic [ddd_pkg::YearW-1:0] hundreds;

  assign hundreds    = ddd_pkg::YearW'(split_i.q100 * 14'd100);
  assign year_div4   = (split_i.year[1:0] == 2'd0);
  assign year_div100 = (split_i.year == hundreds);
  // A century year is a leap year only when its century count is a multiple of four.
  assign leap = year_div100 ? (split_i.q100[1:0] == 2'd0) : year_div4;

  assign dnum_o = ddd_pkg::DnumW'(split_i.year) * 23'd365
                + ddd_pkg::DnumW'(split_i.q4)
                - ddd_pkg::DnumW'(split_i.q100a)
                + ddd_pkg::DnumW'(split_i.q400)
                + ddd_pkg::DnumW'(split_i.doy)
                + ddd_pkg::DnumW'(split_i.late & leap);

endmodule

// ----- test/date_difference_days_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_difference_days_test
// Self-checking bench for the Gregorian day distance pipeline.
// ----------------------------------------------------------------------------
// Date pairs go into the block through the input handshake. For every
// accepted word the bench works out the expected distance with its own day
// count since the start of year 0 and queues it. The checker compares each
// returned word with the oldest queued distance. The run starts with
// calendar extremes and odd dates: leap rules, days past the month end, day
// and month zero, months above twelve, year zero and saturation. Three
// random phases follow, each with its own idle pattern on the two sides.
// ----------------------------------------------------------------------------
module date_difference_days_test;

  typedef logic [ddd_pkg::DistW-1:0] dist_t;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned ResetCycles = 12;
  // About 1650 words with both sides idling at random need far fewer
  // cycles than this; the limit only catches a hung handshake.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseWords  = 540;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned DistCap     = (1 << ddd_pkg::DistW) - 1;

  // Days in the months before month m of a common year. Months zero and
  // one add nothing, months thirteen and up add a whole year.
  localparam int unsigned MonthOffset [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [ddd_pkg::DayW-1:0]     first_day_i;
  logic [ddd_pkg::MonthW-1:0]   first_month_i;
  logic [ddd_pkg::YearW-1:0]    first_year_i;
  logic [ddd_pkg::DayW-1:0]     second_day_i;
  logic [ddd_pkg::MonthW-1:0]   second_month_i;
  logic [ddd_pkg::YearW-1:0]    second_year_i;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [ddd_pkg::DistW-1:0]    day_distance_o;

  dist_t       expected_distances [$];
  dist_t       oldest_distance;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  date_difference_days i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_day_i    (first_day_i),
    .first_month_i  (first_month_i),
    .first_year_i   (first_year_i),
    .second_day_i   (second_day_i),
    .second_month_i (second_month_i),
    .second_year_i  (second_year_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .day_distance_o (day_distance_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Absolute day number of a date, counted from the start of year 0. The
  // whole years before it are counted with the closed leap-year form.
  function automatic int unsigned days_since_year0(
      input logic [ddd_pkg::DayW-1:0]   day,
      input logic [ddd_pkg::MonthW-1:0] month,
      input logic [ddd_pkg::YearW-1:0]  year);
    int unsigned yr;
    int unsigned whole_years;
    int unsigned day_of_year;
    bit          leap;
    yr          = year;
    whole_years = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    day_of_year = MonthOffset[month] + day;
    leap        = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    if (month >= 3 && leap) begin
      day_of_year++;
    end
    return whole_years + day_of_year;
  endfunction

  // Absolute difference of the two day numbers, saturated to the port width.
  function automatic dist_t day_distance(input logic [ddd_pkg::DayW-1:0]   d1,
                                         input logic [ddd_pkg::MonthW-1:0] m1,
                                         input logic [ddd_pkg::YearW-1:0]  y1,
                                         input logic [ddd_pkg::DayW-1:0]   d2,
                                         input logic [ddd_pkg::MonthW-1:0] m2,
                                         input logic [ddd_pkg::YearW-1:0]  y2);
    int unsigned a;
    int unsigned b;
    int unsigned diff;
    a    = days_since_year0(d1, m1, y1);
    b    = days_since_year0(d2, m2, y2);
    diff = (a > b) ? a - b : b - a;
    if (diff > DistCap) begin
      diff = DistCap;
    end
    return dist_t'(diff);
  endfunction

  // Offers one date pair after a random idle gap and returns at the rising
  // edge that accepts it. The valid line is only ever assigned once per
  // falling edge, so a word that follows directly keeps valid high.
  task automatic send_dates(input logic [ddd_pkg::DayW-1:0]   d1,
                            input logic [ddd_pkg::MonthW-1:0] m1,
                            input logic [ddd_pkg::YearW-1:0]  y1,
                            input logic [ddd_pkg::DayW-1:0]   d2,
                            input logic [ddd_pkg::MonthW-1:0] m2,
                            input logic [ddd_pkg::YearW-1:0]  y2);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_day_i    <= d1;
    first_month_i  <= m1;
    first_year_i   <= y1;
    second_day_i   <= d2;
    second_month_i <= m2;
    second_year_i  <= y2;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    expected_distances.push_back(day_distance(d1, m1, y1, d2, m2, y2));
  endtask

  // Holds the sender off until every queued distance has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_distances.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Same and opposite dates at the ends of the year range, plus the full
  // field range so that the saturation path is taken.
  task automatic test_extremes();
    send_dates(5'd1, 4'd1, 14'd1, 5'd1, 4'd1, 14'd1);
    send_dates(5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999);
    send_dates(5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1);
    send_dates(5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'd16383);
    send_dates(5'd31, 4'd15, 14'd16383, 5'd0, 4'd0, 14'd0);
    send_dates(5'd15, 4'd6, 14'd2024, 5'd15, 4'd6, 14'd2024);
  endtask

  // Calendar corner cases: each leap rule, days past the end of the month,
  // day zero, month zero, months above twelve and year zero.
  task automatic test_odd_dates();
    send_dates(5'd28, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000);
    send_dates(5'd28, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900);
    send_dates(5'd28, 4'd2, 14'd2004, 5'd1, 4'd3, 14'd2004);
    send_dates(5'd29, 4'd2, 14'd2023, 5'd1, 4'd3, 14'd2023);
    send_dates(5'd31, 4'd2, 14'd2023, 5'd3, 4'd3, 14'd2023);
    send_dates(5'd31, 4'd2, 14'd2024, 5'd2, 4'd3, 14'd2024);
    send_dates(5'd0, 4'd3, 14'd2023, 5'd28, 4'd2, 14'd2023);
    send_dates(5'd5, 4'd0, 14'd2023, 5'd5, 4'd1, 14'd2023);
    send_dates(5'd1, 4'd13, 14'd2023, 5'd1, 4'd1, 14'd2024);
    send_dates(5'd1, 4'd13, 14'd2020, 5'd1, 4'd1, 14'd2021);
    send_dates(5'd1, 4'd14, 14'd2020, 5'd1, 4'd15, 14'd2020);
    // A month past twelve can push the earlier year's date beyond the
    // later year's, so the sign of the difference flips.
    send_dates(5'd31, 4'd15, 14'd100, 5'd1, 4'd1, 14'd101);
    send_dates(5'd1, 4'd1, 14'd0, 5'd1, 4'd1, 14'd1);
    send_dates(5'd1, 4'd3, 14'd0, 5'd1, 4'd3, 14'd1);
    send_dates(5'd1, 4'd1, 14'd16383, 5'd1, 4'd1, 14'd1);
  endtask

  // Random date pairs. Most keep day 1 to 31 and month 1 to 12, a quarter of
  // all with the second year at most three below the first so that small
  // distances show up, and some use the whole field range.
  task automatic test_random_dates(input int unsigned words, input int unsigned send_pct,
                                   input int unsigned recv_pct);
    logic [ddd_pkg::DayW-1:0]   d1;
    logic [ddd_pkg::DayW-1:0]   d2;
    logic [ddd_pkg::MonthW-1:0] m1;
    logic [ddd_pkg::MonthW-1:0] m2;
    logic [ddd_pkg::YearW-1:0]  y1;
    logic [ddd_pkg::YearW-1:0]  y2;
    int unsigned                kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (words) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        d1 = ddd_pkg::DayW'($urandom);
        m1 = ddd_pkg::MonthW'($urandom);
        y1 = ddd_pkg::YearW'($urandom);
        d2 = ddd_pkg::DayW'($urandom);
        m2 = ddd_pkg::MonthW'($urandom);
        y2 = ddd_pkg::YearW'($urandom);
      end else begin
        d1 = ddd_pkg::DayW'($urandom_range(31, 1));
        m1 = ddd_pkg::MonthW'($urandom_range(12, 1));
        y1 = ddd_pkg::YearW'($urandom_range(9999, 1));
        d2 = ddd_pkg::DayW'($urandom_range(31, 1));
        m2 = ddd_pkg::MonthW'($urandom_range(12, 1));
        if (kind < 40) begin
          y2 = (y1 > 3) ? y1 - ddd_pkg::YearW'($urandom_range(3)) : y1;
        end else begin
          y2 = ddd_pkg::YearW'($urandom_range(9999, 1));
        end
      end
      send_dates(d1, m1, y1, d2, m2, y2);
    end
  endtask

  // The receiver drops ready at random on every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_distances.size() == 0) begin
        $error("day_distance: expected no word, actual %0d", day_distance_o);
        mismatch_count++;
      end else begin
        oldest_distance = expected_distances.pop_front();
        if (day_distance_o !== oldest_distance) begin
          $error("day_distance: expected %0d, actual %0d", oldest_distance,
                 day_distance_o);
          mismatch_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("date_difference_days: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    first_day_i    = '0;
    first_month_i  = '0;
    first_year_i   = '0;
    second_day_i   = '0;
    second_month_i = '0;
    second_year_i  = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The directed words run under the first idle pattern.
    send_idle_pct = 15;
    recv_idle_pct = 50;
    test_extremes();
    test_odd_dates();
    wait_for_results();

    test_random_dates(PhaseWords, 15, 50);
    wait_for_results();
    test_random_dates(PhaseWords, 50, 15);
    wait_for_results();
    test_random_dates(PhaseWords, 0, 0);
    wait_for_results();

    // Let any stray word from the three-stage pipeline show up.
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("date_difference_days: match");
    end else begin
      $display("date_difference_days: mismatch");
    end
    $finish;
  end

endmodule
